### rtl/fbb_pkg.sv
`timescale 1ns / 1ps
package fbb_pkg;

	localparam int MAX_SIZE_DEF = 1024;
	localparam int CHANNEL_BITS_DEF = 16;
	localparam int FS_W = 11;
	localparam logic [FS_W-1:0] FS_RESET = 11'd512;
	localparam int CH_W = 16;
	localparam int POS_W = 10;
	localparam int JPW = 12;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int NBUF = 3;
	localparam logic [3:0] WIN_MAX = 4'd9;

	typedef struct packed {
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} pix_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic run_last;
		logic frame_last;
	} res_t;

	typedef struct packed {
		pix_t pix;
		logic [JPW-1:0] row;
		logic [JPW-1:0] col;
		logic [JPW-1:0] nm1;
		logic [JPW-1:0] i0;
		logic [JPW-1:0] i1;
		logic [JPW-1:0] j0;
		logic [JPW-1:0] j1;
		logic has_out;
		logic [1:0] buf_sel;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WRITE,
		B_READ,
		B_ADD,
		B_DST,
		B_DIV,
		B_OUT
	} back_state_t;

	// Line buffer holding the row that lies age rows above the current one.
	function automatic logic [1:0] buf_of(input logic [1:0] cur, input logic [1:0] age);
		logic [1:0] b;
		b = cur;
		case (age)
			2'd1: b = (cur == 2'd0) ? 2'd2 : cur - 2'd1;
			2'd2: b = (cur == 2'd0) ? 2'd1 : ((cur == 2'd1) ? 2'd2 : 2'd0);
			default: b = cur;
		endcase
		return b;
	endfunction

endpackage

### rtl/fbb_front.sv
`timescale 1ns / 1ps
module fbb_front import fbb_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [FS_W-1:0] cfg_data,
	input  logic in_valid,
	input  logic in_stall,
	input  pix_t in_word,
	output logic push,
	output job_t job
);
	localparam int PW = $clog2(MAX_SIZE);
	localparam logic [CH_W-1:0] CMASK = {CH_W{1'b1}} >> (CH_W - CHANNEL_BITS);

	logic [FS_W-1:0] fs_q;
	logic [PW-1:0] row_q, col_q, nm1;
	logic [1:0] cur_q;
	logic row_hit, col_hit;

	always_comb begin
		if (32'(fs_q) > MAX_SIZE) begin
			nm1 = PW'(MAX_SIZE - 1);
		end else if (fs_q == '0) begin
			nm1 = '0;
		end else begin
			nm1 = PW'(fs_q - 11'd1);
		end
	end

	assign push = in_valid && !in_stall;

	always_comb begin
		job = '0;
		job.pix.in_red = in_word.in_red & CMASK;
		job.pix.in_green = in_word.in_green & CMASK;
		job.pix.in_blue = in_word.in_blue & CMASK;
		job.row = JPW'(row_q);
		job.col = JPW'(col_q);
		job.nm1 = JPW'(nm1);
		job.buf_sel = cur_q;
		row_hit = 1'b1;
		col_hit = 1'b1;
		if (row_q == nm1) begin
			job.i0 = (row_q >= PW'(2)) ? JPW'(row_q - PW'(2)) : '0;
			job.i1 = JPW'(row_q);
		end else if (row_q >= PW'(2)) begin
			job.i0 = JPW'(row_q - PW'(2));
			job.i1 = JPW'(row_q - PW'(2));
		end else begin
			row_hit = 1'b0;
		end
		if (col_q == nm1) begin
			job.j0 = (col_q >= PW'(2)) ? JPW'(col_q - PW'(2)) : '0;
			job.j1 = JPW'(col_q);
		end else if (col_q >= PW'(2)) begin
			job.j0 = JPW'(col_q - PW'(2));
			job.j1 = JPW'(col_q - PW'(2));
		end else begin
			col_hit = 1'b0;
		end
		job.has_out = row_hit && col_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= FS_RESET;
			row_q <= '0;
			col_q <= '0;
			cur_q <= '0;
		end else if (cfg_valid) begin
			fs_q <= cfg_data;
			row_q <= '0;
			col_q <= '0;
		end else if (push) begin
			if (col_q == nm1) begin
				col_q <= '0;
				row_q <= (row_q == nm1) ? '0 : row_q + PW'(1);
				cur_q <= (cur_q == 2'd2) ? 2'd0 : cur_q + 2'd1;
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

endmodule

### rtl/fbb_fifo.sv
`timescale 1ns / 1ps
module fbb_fifo import fbb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t rd_job
);
	job_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0] count_q;

	assign full = (count_q == (QPTR_W+1)'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign rd_job = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

### rtl/fbb_div.sv
`timescale 1ns / 1ps
module fbb_div #(
	parameter int SW = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [SW-1:0] dividend [3],
	input  logic [3:0] divisor,
	output logic done,
	output logic [SW-1:0] quot [3]
);
	localparam int CW = $clog2(SW + 1);

	logic busy_q, done_q;
	logic [CW-1:0] step_q;
	logic [3:0] d_q;
	logic [3:0] rem_q [3];
	logic [SW-1:0] q_q [3];
	logic [4:0] trial [3];

	assign done = done_q;
	assign quot = q_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			trial[c] = {rem_q[c], q_q[c][SW-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= divisor;
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= '0;
				q_q[c] <= dividend[c];
			end
		end else if (busy_q) begin
			for (int c = 0; c < 3; c++) begin
				if (trial[c] >= {1'b0, d_q}) begin
					rem_q[c] <= 4'(trial[c] - {1'b0, d_q});
					q_q[c] <= {q_q[c][SW-2:0], 1'b1};
				end else begin
					rem_q[c] <= trial[c][3:0];
					q_q[c] <= {q_q[c][SW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + CW'(1);
				if (step_q == CW'(SW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/fbb_back.sv
`timescale 1ns / 1ps
module fbb_back import fbb_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_nonempty,
	input  job_t q_job,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_word
);
	localparam int PW = $clog2(MAX_SIZE);
	localparam int CB = CHANNEL_BITS;
	localparam int MW = 3 * CB;
	localparam int SW = CB + 4;

	back_state_t state_q, state_d;
	job_t job_q;
	logic [PW-1:0] i_q, j_q, k_q, l_q;
	logic [PW-1:0] nm1, i0, i1, j0, j1, kend, lend, i_nx, j_nx, age;
	logic [PW:0] ip2, jp2;
	logic [SW-1:0] sum_q [3];
	logic [3:0] cnt_q;
	logic [1:0] bsel_s1;
	logic [MW-1:0] mem [NBUF][MAX_SIZE];
	logic [MW-1:0] rd_q [NBUF];
	logic [MW-1:0] rdata;
	res_t res_q;
	logic mem_we, div_start, div_done, win_end, out_end;
	logic [SW-1:0] quot [3];

	assign nm1 = job_q.nm1[PW-1:0];
	assign i0 = job_q.i0[PW-1:0];
	assign i1 = job_q.i1[PW-1:0];
	assign j0 = job_q.j0[PW-1:0];
	assign j1 = job_q.j1[PW-1:0];
	assign ip2 = {1'b0, i_q} + (PW+1)'(2);
	assign jp2 = {1'b0, j_q} + (PW+1)'(2);
	assign kend = (ip2 <= {1'b0, nm1}) ? ip2[PW-1:0] : nm1;
	assign lend = (jp2 <= {1'b0, nm1}) ? jp2[PW-1:0] : nm1;
	assign age = job_q.row[PW-1:0] - k_q;
	assign win_end = (k_q == kend) && (l_q == lend);
	assign out_end = (i_q == i1) && (j_q == j1);
	assign j_nx = (j_q == j1) ? j0 : j_q + PW'(1);
	assign i_nx = (j_q == j1) ? i_q + PW'(1) : i_q;
	assign rdata = rd_q[bsel_s1];
	assign out_word = res_q;

	fbb_div #(.SW(SW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(sum_q),
		.divisor(cnt_q),
		.done(div_done),
		.quot(quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_nonempty) state_d = B_WRITE;
			B_WRITE: state_d = job_q.has_out ? B_READ : B_IDLE;
			B_READ: state_d = B_ADD;
			B_ADD: state_d = win_end ? B_DST : B_READ;
			B_DST: state_d = B_DIV;
			B_DIV: if (div_done) state_d = B_OUT;
			B_OUT: if (!out_stall) state_d = out_end ? B_IDLE : B_READ;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == B_IDLE) && q_nonempty;
		mem_we = (state_q == B_WRITE);
		div_start = (state_q == B_DST);
		out_valid = (state_q == B_OUT);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[job_q.buf_sel][job_q.col[PW-1:0]] <=
				{job_q.pix.in_red[CB-1:0], job_q.pix.in_green[CB-1:0],
				job_q.pix.in_blue[CB-1:0]};
		end
		for (int b = 0; b < NBUF; b++) begin
			rd_q[b] <= mem[b][l_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		case (state_q)
			B_WRITE: begin
				i_q <= i0;
				j_q <= j0;
				k_q <= i0;
				l_q <= j0;
				cnt_q <= '0;
				for (int c = 0; c < 3; c++) sum_q[c] <= '0;
			end
			B_READ: begin
				bsel_s1 <= buf_of(job_q.buf_sel, age[1:0]);
			end
			B_ADD: begin
				for (int c = 0; c < 3; c++) begin
					sum_q[c] <= sum_q[c] + SW'(rdata[(2-c)*CB +: CB]);
				end
				cnt_q <= cnt_q + 4'd1;
				if (l_q == lend) begin
					l_q <= j_q;
					k_q <= k_q + PW'(1);
				end else begin
					l_q <= l_q + PW'(1);
				end
			end
			B_DIV: begin
				if (div_done) begin
					res_q.out_red <= CH_W'(quot[0]);
					res_q.out_green <= CH_W'(quot[1]);
					res_q.out_blue <= CH_W'(quot[2]);
					res_q.out_row <= POS_W'(i_q);
					res_q.out_col <= POS_W'(j_q);
					res_q.run_last <= out_end;
					res_q.frame_last <= (i_q == nm1) && (j_q == nm1);
				end
			end
			B_OUT: begin
				if (!out_stall && !out_end) begin
					i_q <= i_nx;
					j_q <= j_nx;
					k_q <= i_nx;
					l_q <= j_nx;
					cnt_q <= '0;
					for (int c = 0; c < 3; c++) sum_q[c] <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_win_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DST |-> cnt_q != 4'd0 && cnt_q <= WIN_MAX)
		else $error("window pixel count out of range");
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_q.frame_last |-> res_q.run_last)
		else $error("frame end word is not the end of its run");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV && !div_done |=> state_q == B_DIV)
		else $error("left divide wait before quotient was ready");
`endif

endmodule

### rtl/forward_box_blur_3x3.sv
`timescale 1ns / 1ps
// Clipped 3x3 box filter over a square RGB frame that arrives in raster order.
// Input words enter on in_valid/in_stall and are queued in a four-word buffer, so
// the source keeps sending while results are being computed. Each output word is
// the mean of the window whose top-left corner is its row and column; it comes
// on out_valid/out_stall once the input that completes the window is taken.
// Inside a row one input gives at most one output (three in the last row); at row
// and frame ends a run of up to nine follows, with run_last on its final word and
// frame_last on the corner. Each output reads and sums its window one pixel at a
// time through the line-store read registers, then starts the bit-serial divider,
// waits for its quotients and presents the word. Every input also passes an idle
// and a write state to leave the queue and be stored, which is all that an input
// with no output costs. When out_stall is high the result holds and the queue
// fills; in_stall rises once four words wait.
// The frame size register is written on cfg_valid/cfg_ready, which is always
// ready; a write restarts the frame at row 0, column 0. Reset sets the size to
// 512, clears position and queue; the line stores need no clearing.
module forward_box_blur_3x3 import fbb_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF,
	parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [FS_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  pix_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_word
);
	logic push, pop, q_full, q_nonempty;
	job_t f_job, q_job;

	assign cfg_ready = 1'b1;
	assign in_stall = q_full;

	fbb_front #(.MAX_SIZE(MAX_SIZE), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.push(push),
		.job(f_job)
	);

	fbb_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(f_job),
		.full(q_full),
		.pop(pop),
		.nonempty(q_nonempty),
		.rd_job(q_job)
	);

	fbb_back #(.MAX_SIZE(MAX_SIZE), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_nonempty(q_nonempty),
		.q_job(q_job),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

endmodule
